### rtl/strm_pkg.sv
// Shared types and constants for the segment tree range maximum unit.
// No dependencies.
package strm_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int VAL_W      = 32;
    localparam int MAX_W      = 31;
    // wide enough for a heap number up to 2*P with P up to 2^20
    localparam int TOK_W      = 22;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic                    upd;
        logic [TOK_W-1:0]        l;
        logic [TOK_W-1:0]        r;
        logic signed [VAL_W-1:0] acc;
    } tok_t;

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_RD_A,
        CELL_RD_B,
        CELL_DONE
    } cell_state_t;

    typedef enum logic [1:0] {
        TOP_CLEAR,
        TOP_IDLE,
        TOP_BUSY,
        TOP_OUT
    } top_state_t;

endpackage

### rtl/segment_tree_range_max_unit.sv
// Range maximum segment tree, point update, half-open range query.
// Each level's cell reads its node storage (RD_A, RD_B) and passes the word up
// in DONE; a query result is offered once its word leaves the root. One word in
// flight: in_ready stays low until an update leaves the root or a result is taken.
// Reset: all nodes clear through a sweep of P cycles after reset, during
// which in_ready stays low. Depends on strm_pkg, strm_cell, strm_ram.
module segment_tree_range_max_unit #(
    parameter int LEAVES = strm_pkg::LEAVES_DEF,
    parameter int DEP    = $clog2(LEAVES),
    parameter int RW     = DEP + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [DEP-1:0]       leaf_index,
    input  logic signed [strm_pkg::VAL_W-1:0] write_value,
    input  logic [RW-1:0]        range_low,
    input  logic [RW-1:0]        range_high,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [strm_pkg::MAX_W-1:0] range_max
);
    import strm_pkg::*;

    localparam logic [TOK_W-1:0] PAD    = TOK_W'(1) << DEP;
    localparam logic [TOK_W-1:0] LV_TOK = TOK_W'(LEAVES);

    top_state_t        state_reg, state_next;
    logic [DEP:0]      clr_cnt_reg, clr_cnt_next;
    logic [MAX_W-1:0]  max_reg;
    logic              clr_en, accept, drop, inject;
    logic [TOK_W-1:0]  lo_w, hi_w, lo_c, hi_c;
    tok_t              in_tok;

    // chain links: link[d+1] enters the cell of level d
    logic              link_vld [DEP+2];
    tok_t              link_tok [DEP+2];

    assign clr_en = state_reg == TOP_CLEAR;
    assign accept = in_valid && in_ready;
    // drop updates aimed past the last leaf
    assign drop   = req_type == REQ_UPDATE && TOK_W'(leaf_index) >= LV_TOK;
    assign inject = accept && !drop;

    // clip query bounds to the leaf count
    assign lo_w = TOK_W'(range_low);
    assign hi_w = TOK_W'(range_high);
    assign lo_c = (lo_w > LV_TOK) ? LV_TOK : lo_w;
    assign hi_c = (hi_w > LV_TOK) ? LV_TOK : hi_w;

    always_comb
    begin
        in_tok.upd = req_type == REQ_UPDATE;
        if (req_type == REQ_UPDATE)
        begin
            in_tok.l   = TOK_W'(leaf_index);
            in_tok.r   = '0;
            in_tok.acc = write_value;
        end
        else
        begin
            in_tok.l   = lo_c + PAD;
            in_tok.r   = hi_c + PAD;
            in_tok.acc = '0;
        end
    end

    assign link_vld[DEP+1] = inject;
    assign link_tok[DEP+1] = in_tok;

    // leaf level first, at the input end; each cell hands its word to the parent level
    for (genvar d = 0; d <= DEP; d++)
    begin : g_lvl
        strm_cell #(.LEVEL(d)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr_en   (clr_en),
            .clr_addr (TOK_W'(clr_cnt_reg)),
            .in_vld   (link_vld[d+1]),
            .in_tok   (link_tok[d+1]),
            .out_vld  (link_vld[d]),
            .out_tok  (link_tok[d])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            TOP_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (DEP+1)'((1 << DEP) - 1)) state_next = TOP_IDLE;
            end
            TOP_IDLE: if (inject) state_next = TOP_BUSY;
            TOP_BUSY:
            begin
                if (link_vld[0])
                begin
                    state_next = link_tok[0].upd ? TOP_IDLE : TOP_OUT;
                end
            end
            TOP_OUT:  if (out_ready) state_next = TOP_IDLE;
            default:  state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == TOP_IDLE;
        out_valid = state_reg == TOP_OUT;
        range_max = max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= TOP_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // hold the answer until taken; a query's accumulator starts at zero and never drops below it
    always_ff @(posedge clk)
    begin
        if (state_reg == TOP_BUSY && link_vld[0])
        begin
            max_reg <= link_tok[0].acc[MAX_W-1:0];
        end
    end

endmodule

### rtl/strm_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module strm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/strm_cell.sv
// One tree level: node storage for the level plus the step logic that
// advances a word to the parent level. Depends on strm_pkg, strm_ram.
module strm_cell #(
    parameter int LEVEL = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr_en,
    input  logic [strm_pkg::TOK_W-1:0] clr_addr,
    input  logic                 in_vld,
    input  strm_pkg::tok_t       in_tok,
    output logic                 out_vld,
    output strm_pkg::tok_t       out_tok
);
    import strm_pkg::*;

    localparam int DEPTH = 1 << LEVEL;
    localparam int AW    = (LEVEL > 0) ? LEVEL : 1;

    cell_state_t       state_reg, state_next;
    tok_t              tok_reg;
    logic [VAL_W-1:0]  da_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr, pos_l, pos_r, pos_sib;
    logic [VAL_W-1:0]  wr_data, rd_data;
    logic [TOK_W-1:0]  r_dec;
    logic              active, take_l, take_r;
    logic [TOK_W-1:0]  l_inc, r_new;
    logic signed [VAL_W-1:0] acc_q, acc_u;

    assign r_dec   = tok_reg.r - TOK_W'(1);
    assign pos_l   = (LEVEL > 0) ? tok_reg.l[AW-1:0] : '0;
    assign pos_r   = (LEVEL > 0) ? r_dec[AW-1:0] : '0;
    // the root has no sibling; keep its address inside the single entry
    assign pos_sib = (LEVEL > 0) ? (pos_l ^ AW'(1)) : '0;

    strm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CELL_IDLE: if (in_vld) state_next = CELL_RD_A;
            CELL_RD_A: state_next = CELL_RD_B;
            CELL_RD_B: state_next = CELL_DONE;
            CELL_DONE: state_next = CELL_IDLE;
            default:   state_next = CELL_IDLE;
        endcase
    end

    always_comb
    begin
        wr_en   = clr_en || (state_reg == CELL_RD_A && tok_reg.upd);
        wr_addr = clr_en ? ((LEVEL > 0) ? clr_addr[AW-1:0] : '0) : pos_l;
        wr_data = clr_en ? '0 : tok_reg.acc;
        unique case (state_reg)
            CELL_RD_A: rd_addr = tok_reg.upd ? pos_sib : pos_l;
            default:   rd_addr = pos_r;
        endcase
    end

    // step of the bottom-up walk
    always_comb
    begin
        active = tok_reg.l < tok_reg.r;
        take_l = active && tok_reg.l[0];
        l_inc  = tok_reg.l + TOK_W'(take_l);
        take_r = active && tok_reg.r[0];
        r_new  = take_r ? r_dec : tok_reg.r;
        acc_q  = tok_reg.acc;
        if (take_l && $signed(da_reg) > acc_q)
        begin
            acc_q = $signed(da_reg);
        end
        if (take_r && $signed(rd_data) > acc_q)
        begin
            acc_q = $signed(rd_data);
        end
        acc_u = ($signed(da_reg) > tok_reg.acc) ? $signed(da_reg) : tok_reg.acc;

        out_vld     = state_reg == CELL_DONE;
        out_tok.upd = tok_reg.upd;
        if (tok_reg.upd)
        begin
            out_tok.l   = tok_reg.l >> 1;
            out_tok.r   = tok_reg.r;
            out_tok.acc = acc_u;
        end
        else
        begin
            out_tok.l   = l_inc >> 1;
            out_tok.r   = r_new >> 1;
            out_tok.acc = acc_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CELL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CELL_IDLE && in_vld)
        begin
            tok_reg <= in_tok;
        end
        if (state_reg == CELL_RD_B)
        begin
            da_reg <= rd_data;
        end
    end

endmodule
